// ===== src/vts_pkg.sv =====
// Shared types, constants and helpers for the viewport tile selector.
// Depends on nothing; every other file imports it.
package vts_pkg;

   // Tile grid
   localparam int ROWS    = 4;
   localparam int COLS    = 8;
   localparam int NTILES  = ROWS * COLS;
   localparam int TIDX_W  = (NTILES > 1) ? $clog2(NTILES) : 1;

   // Scaled grid: frame width and height cancel, so all compares are exact
   localparam int POS_W   = 24;
   localparam int TILE_W  = 11520;
   localparam int TILE_H  = 5760;
   localparam int FRAME_W = 5760 * COLS * 2;
   localparam int YAW_OFS = 2880;
   localparam int PIT_OFS = 1440;

   // Field widths
   localparam int FOVH_W  = 13;
   localparam int FOVV_W  = 12;
   localparam int YAW_W   = 13;
   localparam int PIT_W   = 12;
   localparam int TILE_ID_W = 5;

   // Register indexes
   localparam logic CSR_FOV_H = 1'b0;
   localparam logic CSR_FOV_V = 1'b1;

   // Register reset values
   localparam logic [FOVH_W-1:0] FOVH_RESET = FOVH_W'(1600);
   localparam logic [FOVV_W-1:0] FOVV_RESET = FOVV_W'(1440);

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [NTILES-1:0]       mask_type;

   typedef struct packed {
      logic signed [YAW_W-1:0] yaw_angle;
      logic signed [PIT_W-1:0] pitch_angle;
   } req_type;

   typedef struct packed {
      logic [TILE_ID_W-1:0] tile_index;
      logic                 found;
      logic                 last;
   } rsp_type;

   // Unwrapped viewport box
   typedef struct packed {
      pos_type xmin;
      pos_type xmax;
      pos_type ymin;
      pos_type ymax;
   } extent_type;

   // Box after horizontal wrap split
   typedef struct packed {
      pos_type p1min;
      pos_type p1max;
      pos_type p2min;
      pos_type p2max;
      pos_type ymin;
      pos_type ymax;
   } box_type;

   // Strict interval overlap
   function automatic logic overlap(pos_type amin, pos_type amax,
                                    pos_type bmin, pos_type bmax);
      return (amin < bmax) && (amax > bmin);
   endfunction

   // Tile id into the result field, zero-extended or truncated
   function automatic logic [TILE_ID_W-1:0] tile_id(logic [TIDX_W-1:0] idx);
      logic [TIDX_W+TILE_ID_W-1:0] wide;
      wide = (TIDX_W+TILE_ID_W)'(idx);
      return wide[TILE_ID_W-1:0];
   endfunction

endpackage

// ===== src/vts_geom.sv =====
// Box and wrap stages: build the viewport box, then split it at the frame edge.
// Depends on vts_pkg.
module vts_geom
   import vts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [FOVH_W-1:0] fov_horizontal,
   input  logic [FOVV_W-1:0] fov_vertical,
   input  logic              in_valid,
   output logic              in_ready,
   input  req_type           in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output box_type           out_data
);

   logic       s1_valid_ff, s1_valid_in;
   extent_type s1_ff, s1_in;
   logic       s2_valid_ff, s2_valid_in;
   box_type    s2_ff, s2_in;
   logic       s1_ready, s2_ready;
   pos_type    cx, hx, cy, hy;

   // Advance a stage when it is empty or its successor takes its item
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: center and half extent in the scaled grid
   always_comb begin
      cx = (pos_type'(in_data.yaw_angle) + pos_type'(YAW_OFS)) * pos_type'(2 * COLS);
      hx = pos_type'(fov_horizontal) * pos_type'(COLS);
      cy = (pos_type'(PIT_OFS) - pos_type'(in_data.pitch_angle)) * pos_type'(2 * ROWS);
      hy = pos_type'(fov_vertical) * pos_type'(ROWS);
      s1_in.xmin  = cx - hx;
      s1_in.xmax  = cx + hx;
      s1_in.ymin  = cy - hy;
      s1_in.ymax  = cy + hy;
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   // Stage 2: split at the left edge first, then the right edge
   always_comb begin
      s2_in.ymin = s1_ff.ymin;
      s2_in.ymax = s1_ff.ymax;
      if (s1_ff.xmin < pos_type'(0)) begin
         s2_in.p1min = pos_type'(FRAME_W) + s1_ff.xmin;
         s2_in.p1max = pos_type'(FRAME_W);
         s2_in.p2min = pos_type'(0);
         s2_in.p2max = s1_ff.xmax;
      end else if (s1_ff.xmax > pos_type'(FRAME_W)) begin
         s2_in.p1min = pos_type'(0);
         s2_in.p1max = s1_ff.xmax - pos_type'(FRAME_W);
         s2_in.p2min = s1_ff.xmin;
         s2_in.p2max = pos_type'(FRAME_W);
      end else begin
         s2_in.p1min = s1_ff.xmin;
         s2_in.p1max = s1_ff.xmax;
         s2_in.p2min = s1_ff.xmin;
         s2_in.p2max = s1_ff.xmax;
      end
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   // Hold valid bits under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload moves only when its stage advances
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

// ===== src/vts_match.sv =====
// Match stage: compare every tile row and column with the box, form the tile mask.
// Depends on vts_pkg.
module vts_match
   import vts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  box_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output mask_type out_mask
);

   logic            valid_ff, valid_in;
   mask_type        mask_ff, mask_in;
   logic [ROWS-1:0] row_hit;
   logic [COLS-1:0] col_hit;

   assign in_ready = !valid_ff || out_ready;

   // Compare tile extents with both wrapped parts and the vertical span
   always_comb begin
      pos_type tmin;
      pos_type tmax;
      for (int c = 0; c < COLS; c++) begin
         tmin = pos_type'(c * TILE_W);
         tmax = pos_type'((c + 1) * TILE_W);
         col_hit[c] = overlap(tmin, tmax, in_data.p1min, in_data.p1max) ||
                      overlap(tmin, tmax, in_data.p2min, in_data.p2max);
      end
      for (int r = 0; r < ROWS; r++) begin
         tmin = pos_type'(r * TILE_H);
         tmax = pos_type'((r + 1) * TILE_H);
         row_hit[r] = overlap(tmin, tmax, in_data.ymin, in_data.ymax);
      end
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            mask_in[r*COLS + c] = row_hit[r] & col_hit[c];
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         mask_ff <= mask_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mask  = mask_ff;

endmodule

// ===== src/vts_emit.sv =====
// Emitter: walk one tile mask lowest bit first, one result per cycle while the output is not stalled,
// into the result register. Depends on vts_pkg.
module vts_emit
   import vts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  mask_type in_mask,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   logic              busy_ff, busy_in;
   mask_type          mask_ff, mask_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   mask_type          lowbit, remain;
   logic [TIDX_W-1:0] idx;
   logic              load_out, rem_zero, take;

   // Isolate the lowest pending tile and what is left after it
   always_comb begin
      lowbit   = mask_ff & (~mask_ff + mask_type'(1));
      remain   = mask_ff & ~lowbit;
      rem_zero = (remain == '0);
      idx      = '0;
      for (int i = 0; i < NTILES; i++) begin
         if (lowbit[i]) begin
            idx = idx | TIDX_W'(i);
         end
      end
   end

   // Issue a result when the output register is free or being drained
   assign load_out = busy_ff && (!out_valid_ff || rsp_ready);
   assign in_ready = !busy_ff || (load_out && rem_zero);
   assign take     = in_valid && in_ready;

   always_comb begin
      out_in.found      = (mask_ff != '0);
      out_in.tile_index = out_in.found ? tile_id(idx) : '0;
      out_in.last       = rem_zero;

      busy_in = busy_ff;
      mask_in = mask_ff;
      if (take) begin
         busy_in = 1'b1;
         mask_in = in_mask;
      end else if (load_out) begin
         busy_in = !rem_zero;
         mask_in = remain;
      end

      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (load_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== src/viewport_tile_selector_unit.sv =====
// Viewport tile selector: a request passes the box, wrap and match stages and the emitter to its
// first result; then one result per cycle while rsp_ready allows. The emitter gives one result
// per matching tile (at most ROWS*COLS = 32), or one no-match result, and takes the next mask
// as it issues the last; otherwise requests enter one per cycle unless the output stalls.
// Synchronous reset empties the pipeline and loads the default fields of view.
// Depends on vts_pkg, vts_geom, vts_match and vts_emit.
module viewport_tile_selector_unit
   import vts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [FOVH_W-1:0] csr_wdata
);

   logic [FOVH_W-1:0] fov_h_ff, fov_h_in;
   logic [FOVV_W-1:0] fov_v_ff, fov_v_in;
   logic              box_valid, box_ready;
   box_type           box_data;
   logic              mask_valid, mask_ready;
   mask_type          mask_data;

   // Take every register transfer at once
   assign csr_ready = 1'b1;

   always_comb begin
      fov_h_in = fov_h_ff;
      fov_v_in = fov_v_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FOV_H: fov_h_in = csr_wdata;
            CSR_FOV_V: fov_v_in = csr_wdata[FOVV_W-1:0];
            default:   fov_h_in = fov_h_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_h_ff <= FOVH_RESET;
         fov_v_ff <= FOVV_RESET;
      end else begin
         fov_h_ff <= fov_h_in;
         fov_v_ff <= fov_v_in;
      end
   end

   vts_geom u_geom (
      .clock          (clock),
      .reset          (reset),
      .fov_horizontal (fov_h_ff),
      .fov_vertical   (fov_v_ff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_data        (req_payload),
      .out_valid      (box_valid),
      .out_ready      (box_ready),
      .out_data       (box_data)
   );

   vts_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (box_valid),
      .in_ready  (box_ready),
      .in_data   (box_data),
      .out_valid (mask_valid),
      .out_ready (mask_ready),
      .out_mask  (mask_data)
   );

   vts_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mask_valid),
      .in_ready    (mask_ready),
      .in_mask     (mask_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/vts_checker.sv =====
// Port-level checks for the viewport tile selector, bound to the top level.
// Depends on vts_pkg and viewport_tile_selector_unit.
module vts_checker
   import vts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // A no-match result stands alone with tile zero
   a_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |->
         rsp_payload.last && (rsp_payload.tile_index == '0))
      else $error("no-match result malformed");

   // Only a real tile may be followed by more results
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> rsp_payload.found)
      else $error("non-final result without a tile");

   // Come out of reset with no result pending
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind viewport_tile_selector_unit vts_checker u_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking bench for viewport_tile_selector_unit: drives head poses and
// field-of-view writes, predicts every selected tile and compares each transfer.
// Depends on vts_pkg and the RTL under src.
module tb_top;
   import vts_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int MAX_WAIT     = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_POSES  = 55;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic              csr_index   = CSR_FOV_H;
   logic [FOVH_W-1:0] csr_wdata   = '0;

   // Predictor copy of the field-of-view registers
   logic [FOVH_W-1:0] fov_h_now = FOVH_RESET;
   logic [FOVV_W-1:0] fov_v_now = FOVV_RESET;

   rsp_type expected_tiles[$];
   int      mismatch_count = 0;
   int      ready_hold     = 0;
   bit      no_idle        = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   viewport_tile_selector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   function automatic int pick_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic bit spans_cross(longint lo_a, longint hi_a, longint lo_b, longint hi_b);
      return (lo_a < hi_b) && (hi_a > lo_b);
   endfunction

   // Queue the tiles that the viewport box around this pose overlaps, row-major
   function automatic void predict_tiles(logic signed [YAW_W-1:0] yaw,
                                         logic signed [PIT_W-1:0] pitch);
      longint  cx, hx, cy, hy, xmin, xmax, ymin, ymax;
      longint  amin, amax, bmin, bmax, row_lo, col_lo;
      int      hits;
      rsp_type tile;
      cx   = (longint'(yaw) + YAW_OFS) * COLS * 2;
      hx   = longint'(fov_h_now) * COLS;
      cy   = (PIT_OFS - longint'(pitch)) * ROWS * 2;
      hy   = longint'(fov_v_now) * ROWS;
      xmin = cx - hx;
      xmax = cx + hx;
      ymin = cy - hy;
      ymax = cy + hy;
      // Split the box into two spans when it wraps past a frame edge
      if (xmin < 0) begin
         amin = FRAME_W + xmin; amax = FRAME_W;
         bmin = 0;              bmax = xmax;
      end else if (xmax > FRAME_W) begin
         amin = 0;              amax = xmax - FRAME_W;
         bmin = xmin;           bmax = FRAME_W;
      end else begin
         amin = xmin;           amax = xmax;
         bmin = xmin;           bmax = xmax;
      end
      hits = 0;
      for (int r = 0; r < ROWS; r++) begin
         row_lo = longint'(r) * TILE_H;
         if (spans_cross(row_lo, row_lo + TILE_H, ymin, ymax)) begin
            for (int c = 0; c < COLS; c++) begin
               col_lo = longint'(c) * TILE_W;
               if (spans_cross(col_lo, col_lo + TILE_W, amin, amax) ||
                   spans_cross(col_lo, col_lo + TILE_W, bmin, bmax)) begin
                  tile.tile_index = TILE_ID_W'(r * COLS + c);
                  tile.found      = 1'b1;
                  tile.last       = 1'b0;
                  expected_tiles.push_back(tile);
                  hits++;
               end
            end
         end
      end
      // Flag the final tile, or stand in a single no-match result
      if (hits == 0) begin
         tile.tile_index = '0;
         tile.found      = 1'b0;
         tile.last       = 1'b1;
         expected_tiles.push_back(tile);
      end else begin
         tile      = expected_tiles.pop_back();
         tile.last = 1'b1;
         expected_tiles.push_back(tile);
      end
   endfunction

   task automatic compare_tile(input rsp_type got);
      rsp_type want;
      if (expected_tiles.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("unexpected result: tile %0d found %0b last %0b",
                     got.tile_index, got.found, got.last);
         mismatch_count++;
      end else begin
         want = expected_tiles.pop_front();
         if (got.tile_index !== want.tile_index || got.found !== want.found ||
             got.last !== want.last) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("mismatch: expected tile %0d found %0b last %0b, got tile %0d found %0b last %0b",
                        want.tile_index, want.found, want.last,
                        got.tile_index, got.found, got.last);
            mismatch_count++;
         end
      end
   endtask

   // Check each result transfer, then hold ready low for a random stall
   always @(posedge clock) begin
      if (reset) begin
         ready_hold = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            compare_tile(rsp_payload);
            ready_hold = pick_wait();
         end else if (ready_hold > 0) begin
            ready_hold--;
         end
         rsp_ready <= (ready_hold == 0);
      end
   end

   // Offer one pose and predict its tiles once the transfer happens
   task automatic send_pose(input int yaw, input int pitch);
      int      gap;
      req_type pose;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pose.yaw_angle   = YAW_W'(yaw);
      pose.pitch_angle = PIT_W'(pitch);
      req_valid   <= 1'b1;
      req_payload <= pose;
      do @(posedge clock); while (!req_ready);
      predict_tiles(pose.yaw_angle, pose.pitch_angle);
   endtask

   // Drop valid and wait until every queued tile has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tiles.size() != 0);
   endtask

   task automatic write_register(input logic idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= FOVH_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FOV_H)
         fov_h_now = FOVH_W'(value);
      else
         fov_v_now = FOVV_W'(value);
   endtask

   // Reprogram both fields of view with the block idle
   task automatic set_view(input int fov_h, input int fov_v);
      drain_results();
      write_register(CSR_FOV_H, fov_h);
      write_register(CSR_FOV_V, fov_v);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_view();
      send_pose(0, 0);
      send_pose(-2880, 0);
      send_pose(2880, 0);
      send_pose(0, 1440);
      send_pose(0, -1440);
      send_pose(1000, 700);
   endtask

   // Point-sized box: a tile corner gives no match, an interior point one tile
   task automatic test_zero_view();
      set_view(0, 0);
      send_pose(0, 0);
      send_pose(180, 360);
      send_pose(-2880, 1440);
   endtask

   // Full-frame and oversized boxes, at and across the frame edges
   task automatic test_wide_view();
      set_view(5760, 2880);
      send_pose(0, 0);
      send_pose(-2880, -1440);
      send_pose(2880, 1440);
      set_view(8191, 8191);
      send_pose(100, -200);
      send_pose(-1, 1);
   endtask

   task automatic test_edge_crossing();
      set_view(1600, 200);
      send_pose(-2800, 0);
      send_pose(2800, 0);
      send_pose(-2880, 300);
   endtask

   // Poses beyond the nominal range, box partly or wholly off the frame
   task automatic test_out_of_range();
      set_view(1, 1);
      send_pose(-4096, -2048);
      send_pose(4095, 2047);
      send_pose(-4096, 2047);
      send_pose(4095, -2048);
   endtask

   task automatic test_random_poses();
      int yaw, pitch, pick;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: set_view($urandom_range(1, 64), $urandom_range(1, 64));
            2: set_view(5760, 2880);
            3: set_view($urandom_range(0, 8191), $urandom_range(0, 8191));
            default: set_view($urandom_range(1, 5760), $urandom_range(1, 2880));
         endcase
         no_idle = (phase == 4);
         for (int n = 0; n < PHASE_POSES; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               yaw   = int'($urandom_range(0, 8191)) - 4096;
               pitch = int'($urandom_range(0, 4095)) - 2048;
            end else if (pick <= 2) begin
               yaw   = ($urandom_range(0, 1) ? 2880 : -2880) +
                       int'($urandom_range(0, 400)) - 200;
               pitch = int'($urandom_range(0, 2880)) - 1440;
            end else begin
               yaw   = int'($urandom_range(0, 5760)) - 2880;
               pitch = int'($urandom_range(0, 2880)) - 1440;
            end
            send_pose(yaw, pitch);
         end
      end
      no_idle = 1'b0;
   endtask

   // Give up if the run hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** viewport_tile_selector_unit: FAILED **");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_view();
      test_zero_view();
      test_wide_view();
      test_edge_crossing();
      test_out_of_range();
      test_random_poses();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** viewport_tile_selector_unit: PASSED **");
      else
         $display("** viewport_tile_selector_unit: FAILED **");
      $finish;
   end

endmodule
